// ----- sv/array_list_engine_top_assert.svh -----
// Assertion macros shared by the array list engine RTL.
`ifndef ARRAY_LIST_ENGINE_TOP_ASSERT_SVH
`define ARRAY_LIST_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTH
`define ALE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ALE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ALE_ASSERT_IMP(lbl, ante, cons, msg)
`define ALE_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- sv/alist_pkg.sv -----
// Shared types and constants for the array list engine.
package alist_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 4;
  localparam int CNT_W        = 5;
  localparam int CAPACITY_DEF = 16;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_MODIFY = 2'd1,
    OP_APPEND = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

endpackage

// ----- sv/array_list_engine_top.sv -----
// Array list engine: packed list of signed 32-bit entries with find, modify, append, remove.
//
// One operation is taken at a time and answers with one result beat. Append and
// out-of-range requests go from the execute state straight to the result state;
// modify first passes a state that takes the old entry. Find walks the stored
// entries through the single read port of the entry memory, one entry per cycle,
// until a match or the end of the list. Remove walks from the given index to the
// list end, reading one entry and writing it one slot lower each cycle. A finished
// result sits in an output register, so the next operation may be accepted while it waits.
module array_list_engine_top #(
  parameter int CAPACITY = alist_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_opcode,
  input  alist_pkg::pos_t             in_position,
  input  logic signed [alist_pkg::DATA_W-1:0] in_operand_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output alist_pkg::pos_t             out_found_position,
  output logic signed [alist_pkg::DATA_W-1:0] out_old_value,
  output alist_pkg::cnt_t             out_entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int XW = (CW > alist_pkg::POS_W) ? CW : alist_pkg::POS_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_FIND = 6'b000100,
    S_REM  = 6'b001000,
    S_MOD  = 6'b010000,
    S_RESP = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic                cmp_v_r, cmp_v_nxt;
  logic [1:0]          op_r;
  alist_pkg::pos_t     pos_r;
  alist_pkg::data_t    val_r;
  logic [1:0]          res_status_r, res_status_nxt;
  logic [CW-1:0]       res_pos_r, res_pos_nxt;
  alist_pkg::data_t    res_old_r, res_old_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_status_r;
  alist_pkg::pos_t     out_pos_r;
  alist_pkg::data_t    out_old_r;
  alist_pkg::cnt_t     out_count_r;

  alist_pkg::data_t    mem [CAPACITY];
  alist_pkg::data_t    rd_data_r;
  logic [IW-1:0]       rd_addr;
  logic [IW-1:0]       wr_addr;
  alist_pkg::data_t    wr_data;
  logic                wr_en;

  logic                in_acc;
  logic                in_range;
  logic                issue;
  logic                hit;
  logic                load_out;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign in_range  = XW'(pos_r) < XW'(count_r);
  assign issue     = idx_r < count_r;
  // The single comparator of the scan: the entry read last cycle against the key.
  assign hit       = (rd_data_r == val_r);
  assign load_out  = (state_r == S_RESP) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_v_nxt      = cmp_v_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    res_old_nxt    = res_old_r;
    rd_addr        = IW'(idx_r);
    wr_addr        = IW'(pos_r);
    wr_data        = val_r;
    wr_en          = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_status_nxt = alist_pkg::ST_OK;
        res_pos_nxt    = '0;
        res_old_nxt    = '0;
        idx_nxt        = '0;
        cmp_v_nxt      = 1'b0;
        rd_addr        = IW'(pos_r);
        unique case (op_r)
          alist_pkg::OP_FIND: begin
            state_nxt = S_FIND;
          end
          alist_pkg::OP_MODIFY: begin
            if (in_range) begin
              // The read port returns the old entry while the new value goes in.
              wr_en     = 1'b1;
              state_nxt = S_MOD;
            end else begin
              res_status_nxt = alist_pkg::ST_RANGE;
              state_nxt      = S_RESP;
            end
          end
          alist_pkg::OP_APPEND: begin
            if (count_r < CW'(CAPACITY)) begin
              wr_en     = 1'b1;
              wr_addr   = IW'(count_r);
              count_nxt = count_r + CW'(1);
            end else begin
              res_status_nxt = alist_pkg::ST_FULL;
            end
            state_nxt = S_RESP;
          end
          default: begin
            if (in_range) begin
              idx_nxt   = CW'(pos_r);
              state_nxt = S_REM;
            end else begin
              res_status_nxt = alist_pkg::ST_RANGE;
              state_nxt      = S_RESP;
            end
          end
        endcase
      end
      S_FIND: begin
        cmp_v_nxt   = issue;
        cmp_idx_nxt = idx_r;
        idx_nxt     = idx_r + CW'(1);
        if (cmp_v_r && hit) begin
          res_pos_nxt = cmp_idx_r;
          state_nxt   = S_RESP;
        end else if (!issue) begin
          res_status_nxt = alist_pkg::ST_MISSING;
          state_nxt      = S_RESP;
        end
      end
      S_REM: begin
        // Read one entry ahead and write the previous one a slot lower.
        cmp_v_nxt   = issue;
        cmp_idx_nxt = idx_r;
        idx_nxt     = idx_r + CW'(1);
        wr_addr     = IW'(cmp_idx_r - CW'(1));
        wr_data     = rd_data_r;
        if (cmp_v_r) begin
          if (XW'(cmp_idx_r) == XW'(pos_r)) begin
            res_old_nxt = rd_data_r;
          end else begin
            wr_en = 1'b1;
          end
        end
        if (!issue) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_RESP;
        end
      end
      S_MOD: begin
        res_old_nxt = rd_data_r;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    res_old_r    <= res_old_nxt;
    if (in_acc) begin
      op_r  <= in_opcode;
      pos_r <= in_position;
      val_r <= in_operand_value;
    end
    if (load_out) begin
      out_status_r <= res_status_r;
      out_pos_r    <= alist_pkg::pos_t'(res_pos_r);
      out_old_r    <= res_old_r;
      out_count_r  <= alist_pkg::cnt_t'(count_r);
    end
  end

  // Entry store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_pos_r;
  assign out_old_value      = out_old_r;
  assign out_entry_count    = out_count_r;

`include "array_list_engine_top_assert.svh"

  `ALE_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(CAPACITY), "count above capacity")
  `ALE_ASSERT_IMP(a_scan_bound, (state_r == S_FIND) && cmp_v_r, cmp_idx_r < count_r, "scan overrun")
  `ALE_ASSERT_NXT(a_idle_hold, (state_r == S_IDLE) && !in_acc, $stable(count_r), "count moved")

endmodule

// ----- tb/array_list_engine_top_tb.sv -----
// Self-checking testbench for the array list engine: directed and random operations.
`timescale 1ns / 100ps

module array_list_engine_top_tb;

  localparam int LIST_DEPTH     = alist_pkg::CAPACITY_DEF;
  localparam int IDLE_PCT       = 12;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 2 * LIST_DEPTH + 8;

  typedef struct packed {
    alist_pkg::status_t status;
    alist_pkg::pos_t    found_pos;
    alist_pkg::data_t   old_value;
    alist_pkg::cnt_t    entry_count;
  } list_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_opcode;
  alist_pkg::pos_t in_position;
  logic signed [alist_pkg::DATA_W-1:0] in_operand_value;
  logic out_valid;
  logic out_ready;
  logic [1:0] out_status;
  alist_pkg::pos_t out_found_position;
  logic signed [alist_pkg::DATA_W-1:0] out_old_value;
  alist_pkg::cnt_t out_entry_count;

  // Shadow copy of the list that the engine holds.
  alist_pkg::data_t list_model [LIST_DEPTH];
  int unsigned list_len;
  list_result_t pending_results [$];

  int fail_count;
  int stall_cycles;
  int stall_req;
  int stall_left;
  bit tx_quiet;
  bit rx_quiet;

  array_list_engine_top #(.CAPACITY(LIST_DEPTH)) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_position        (in_position),
    .in_operand_value   (in_operand_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_old_value      (out_old_value),
    .out_entry_count    (out_entry_count)
  );

  always #6 clk = ~clk;

  // Applies one operation to the shadow list and queues the result it must give.
  task automatic apply_list_op(alist_pkg::op_t op, alist_pkg::pos_t pos,
                               alist_pkg::data_t val);
    list_result_t res;
    int unsigned i;
    res.status      = alist_pkg::ST_OK;
    res.found_pos   = '0;
    res.old_value   = '0;
    case (op)
      alist_pkg::OP_FIND: begin
        res.status = alist_pkg::ST_MISSING;
        for (i = 0; i < list_len; i++) begin
          if (list_model[i] == val) begin
            res.status    = alist_pkg::ST_OK;
            res.found_pos = alist_pkg::pos_t'(i);
            break;
          end
        end
      end
      alist_pkg::OP_MODIFY: begin
        if (pos < list_len) begin
          res.old_value   = list_model[pos];
          list_model[pos] = val;
        end else begin
          res.status = alist_pkg::ST_RANGE;
        end
      end
      alist_pkg::OP_APPEND: begin
        if (list_len < LIST_DEPTH) begin
          list_model[list_len] = val;
          list_len++;
        end else begin
          res.status = alist_pkg::ST_FULL;
        end
      end
      default: begin
        if (pos < list_len) begin
          res.old_value = list_model[pos];
          for (i = pos; i + 1 < list_len; i++) list_model[i] = list_model[i + 1];
          list_len--;
        end else begin
          res.status = alist_pkg::ST_RANGE;
        end
      end
    endcase
    res.entry_count = alist_pkg::cnt_t'(list_len);
    pending_results.push_back(res);
  endtask

  // Drives one beat on the input channel and waits for it to be taken.
  task automatic send_op(alist_pkg::op_t op, alist_pkg::pos_t pos, alist_pkg::data_t val);
    @(negedge clk);
    if (!tx_quiet) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid         <= 1'b0;
        in_opcode        <= 2'($urandom);
        in_position      <= alist_pkg::pos_t'($urandom);
        in_operand_value <= $urandom;
        @(negedge clk);
      end
    end
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_position      <= pos;
    in_operand_value <= val;
    do @(posedge clk); while (!in_ready);
    apply_list_op(op, pos, val);
  endtask

  function automatic alist_pkg::data_t pick_value();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40 && list_len != 0) return list_model[$urandom_range(list_len - 1)];
    if (roll < 55) begin
      case ($urandom_range(4))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        3: return 32'hFFFF_FFFF;
        default: return 32'h0000_0001;
      endcase
    end
    return $urandom;
  endfunction

  function automatic alist_pkg::pos_t pick_position();
    if (list_len != 0 && $urandom_range(99) < 75) begin
      return alist_pkg::pos_t'($urandom_range(list_len - 1));
    end
    return alist_pkg::pos_t'($urandom_range(15));
  endfunction

  // Random operations steered toward a fill level that moves now and then.
  task automatic run_random_ops(int unsigned n_ops);
    int unsigned n;
    int unsigned goal;
    int unsigned roll;
    alist_pkg::op_t op;
    goal = 0;
    for (n = 0; n < n_ops; n++) begin
      if (n % 50 == 0) begin
        if ($urandom_range(3) == 0) goal = $urandom_range(1) ? LIST_DEPTH : 0;
        else goal = $urandom_range(LIST_DEPTH);
      end
      roll = $urandom_range(99);
      if (roll < 25) op = alist_pkg::OP_FIND;
      else if (roll < 45) op = alist_pkg::OP_MODIFY;
      else if (roll < 55) op = alist_pkg::op_t'($urandom_range(3));
      else if (list_len < goal) op = alist_pkg::OP_APPEND;
      else if (list_len > goal) op = alist_pkg::OP_REMOVE;
      else op = roll[0] ? alist_pkg::OP_APPEND : alist_pkg::OP_REMOVE;
      send_op(op, pick_position(), pick_value());
    end
  endtask

  task automatic test_empty_list();
    send_op(alist_pkg::OP_FIND, 4'd0, 32'h0000_0000);
    send_op(alist_pkg::OP_MODIFY, 4'd0, 32'h7FFF_FFFF);
    send_op(alist_pkg::OP_REMOVE, 4'd15, 32'h8000_0000);
  endtask

  task automatic test_fill_to_capacity();
    int unsigned i;
    alist_pkg::data_t val;
    for (i = 0; i < LIST_DEPTH; i++) begin
      case (i)
        0:  val = 32'h8000_0000;
        1:  val = 32'h7FFF_FFFF;
        2:  val = 32'h0000_0000;
        3:  val = 32'hFFFF_FFFF;
        9:  val = 32'h7FFF_FFFF;
        15: val = 32'h5A5A_A5A5;
        default: val = $urandom;
      endcase
      send_op(alist_pkg::OP_APPEND, alist_pkg::pos_t'($urandom), val);
    end
    send_op(alist_pkg::OP_APPEND, 4'd15, 32'h0000_0001);
  endtask

  task automatic test_find_modify_remove();
    // The duplicate at index 9 must not hide the first match at index 1.
    send_op(alist_pkg::OP_FIND, 4'd0, 32'h7FFF_FFFF);
    send_op(alist_pkg::OP_FIND, 4'd7, 32'h5A5A_A5A5);
    send_op(alist_pkg::OP_MODIFY, 4'd0, 32'hFFFF_FFFF);
    send_op(alist_pkg::OP_REMOVE, 4'd15, 32'h0000_0000);
    send_op(alist_pkg::OP_REMOVE, 4'd0, 32'h0000_0000);
  endtask

  task automatic test_streaming();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    run_random_ops(150);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    int unsigned n;
    tx_quiet  = 1'b1;
    stall_req = 300;
    for (n = 0; n < 40; n++) begin
      send_op(alist_pkg::op_t'($urandom_range(3)), pick_position(), pick_value());
    end
    tx_quiet = 1'b0;
  endtask

  // Result side: random stalls plus an occasional long hold-off on request.
  always @(negedge clk) begin
    if (stall_req != 0) begin
      stall_left = stall_req;
      stall_req  = 0;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= rx_quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: status %0d count %0d", out_status, out_entry_count);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_found_position !== want.found_pos) begin
          $error("found_position: expected %0d, got %0d", want.found_pos, out_found_position);
          fail_count++;
        end
        if (out_old_value !== want.old_value) begin
          $error("old_value: expected %0d, got %0d", $signed(want.old_value), out_old_value);
          fail_count++;
        end
        if (out_entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, out_entry_count);
          fail_count++;
        end
      end
    end
  end

  // Ends the run when neither channel has moved a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_opcode        = '0;
    in_position      = '0;
    in_operand_value = '0;
    out_ready        = 1'b0;
    list_len         = 0;
    fail_count       = 0;
    stall_cycles     = 0;
    stall_req        = 0;
    stall_left       = 0;
    tx_quiet         = 1'b0;
    rx_quiet         = 1'b0;
    foreach (list_model[i]) list_model[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_fill_to_capacity();
    test_find_modify_remove();
    test_streaming();
    test_backpressure();
    run_random_ops(800);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/alist_pkg.sv
sv/array_list_engine_top.sv
tb/array_list_engine_top_tb.sv
